### rtl/prid_pkg.sv
// Shared types and constants for the palette RLE image decoder.
// No dependencies; every other file imports this package.
package prid_pkg;

  localparam int DIM_W       = 13;   // image_width / image_height register width
  localparam int TOTAL_W     = 25;   // width*height, up to 4096*4096
  localparam int POS_W       = 24;   // pixel offset
  localparam int RUN_W       = 7;    // run length
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = 8;
  localparam int CFG_AW      = 4;    // three 32-bit registers at 0, 4, 8

  // action codes of an input beat
  localparam logic [1:0] ACT_PAL_WRITE = 2'd0;
  localparam logic [1:0] ACT_START     = 2'd1;
  localparam logic [1:0] ACT_DATA      = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_FLAGS  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // format_flags bit positions
  localparam int FLG_TRANSP  = 0;
  localparam int FLG_RLE     = 5;
  localparam int FLG_OWN_PAL = 7;

  // stream byte thresholds
  localparam logic [7:0] RLE_RUN_BASE = 8'd128;
  localparam logic [7:0] REPEAT_BASE  = 8'd192;

  // magenta key colours of an own palette
  localparam logic [7:0] KEY0_R = 8'd255;
  localparam logic [7:0] KEY0_G = 8'd0;
  localparam logic [7:0] KEY0_B = 8'd132;
  localparam logic [7:0] KEY1_R = 8'd252;
  localparam logic [7:0] KEY1_G = 8'd2;
  localparam logic [7:0] KEY1_B = 8'd132;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // red in the low byte, alpha in the high byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  typedef struct packed {
    logic own_palette;
    logic transparent;
    logic plain;
  } colour_ctrl_t;

endpackage

### rtl/prid_in_if.sv
// Input stream channel of the decoder: valid/ready plus one stream item.
// Depends on prid_pkg.
interface prid_in_if import prid_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  data_byte;
  logic [7:0]  entry_index;
  logic [7:0]  entry_red;
  logic [7:0]  entry_green;
  logic [7:0]  entry_blue;
  logic [7:0]  entry_alpha;

  modport source (
    output valid, action, data_byte, entry_index,
    output entry_red, entry_green, entry_blue, entry_alpha,
    input  ready
  );
  modport sink (
    input  valid, action, data_byte, entry_index,
    input  entry_red, entry_green, entry_blue, entry_alpha,
    output ready
  );
endinterface

### rtl/prid_out_if.sv
// Result channel of the decoder: valid/ready plus one pixel run.
// Depends on prid_pkg.
interface prid_out_if import prid_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   pixel_offset;
  logic [RUN_W-1:0]   run_length;
  logic [7:0]         pixel_red;
  logic [7:0]         pixel_green;
  logic [7:0]         pixel_blue;
  logic [7:0]         pixel_alpha;
  logic               image_done;

  modport source (
    output valid, pixel_offset, run_length, pixel_red, pixel_green,
    output pixel_blue, pixel_alpha, image_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_offset, run_length, pixel_red, pixel_green,
    input  pixel_blue, pixel_alpha, image_done,
    output ready
  );
endinterface

### rtl/prid_colour_map.sv
// Palette colour mapping: own-palette key substitution and the black alpha rule.
// Depends on prid_pkg.
module prid_colour_map import prid_pkg::*; (
  input  rgba_t        entry,
  input  colour_ctrl_t ctrl,
  output rgba_t        colour
);

  logic  is_key;
  rgba_t keyed;

  assign is_key = ctrl.own_palette &&
                  ((entry.red == KEY0_R && entry.green == KEY0_G && entry.blue == KEY0_B) ||
                   (entry.red == KEY1_R && entry.green == KEY1_G && entry.blue == KEY1_B));

  assign keyed = is_key ? '0 : entry;

  always_comb begin
    colour = keyed;
    // black in plain mode: alpha comes from the transparent flag
    if (ctrl.plain && keyed.red == 8'd0 && keyed.green == 8'd0 && keyed.blue == 8'd0) begin
      colour       = '0;
      colour.alpha = ctrl.transparent ? 8'd0 : ALPHA_OPAQUE;
    end
  end

endmodule

### rtl/palette_rle_image_decoder_core.sv
// Palette RLE image decoder, top level. Depends on prid_pkg, prid_in_if,
// prid_out_if and prid_colour_map.
// Throughput: one beat per cycle while the output register is empty or being taken;
// the palette RAM read and the decode step each take one register stage, and the
// output register decouples a stalled sink.
// Reset (rst_n, synchronous): decoder idle, position and count zero, registers at
// their reset values; palette RAM contents stay undefined until written.
module palette_rle_image_decoder_core import prid_pkg::*; #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  prid_in_if.sink           in_chan,
  prid_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_LITERAL = 2'd2,
    PH_REPEAT  = 2'd3
  } phase_t;

  // ---------------- configuration registers ----------------
  logic [7:0]       flags_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic [TOTAL_W-1:0] total_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r  <= '0;
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FLAGS:  flags_r  <= pwdata[7:0];
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FLAGS:  prdata = {24'd0, flags_r};
      REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_r};
      REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_r};
      default:    prdata = '0;
    endcase
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
    return r;
  endfunction

  // image size product, settled by the time an item accepted after a config write reaches decode
  always_ff @(posedge clk) begin
    if (!rst_n) total_r <= TOTAL_W'(1);
    else        total_r <= TOTAL_W'(clamp_dim(width_r)) * TOTAL_W'(clamp_dim(height_r));
  end

  // ---------------- stage 1: input register and palette read ----------------
  logic             in_acc;
  logic             s1_v_r, s1_go;
  logic [1:0]       s1_action_r;
  logic [7:0]       s1_byte_r;
  rgba_t            pal_rd_r;
  rgba_t            pal_mem [PAL_ENTRIES];
  logic             out_v_r;

  assign s1_go          = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready  = !s1_v_r || s1_go;
  assign in_acc         = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.action == ACT_PAL_WRITE) begin
      pal_mem[in_chan.entry_index] <= '{alpha: in_chan.entry_alpha, blue: in_chan.entry_blue,
                                        green: in_chan.entry_green, red: in_chan.entry_red};
    end
    if (in_acc) begin
      pal_rd_r <= pal_mem[in_chan.data_byte];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
    if (in_acc) begin
      s1_action_r <= in_chan.action;
      s1_byte_r   <= in_chan.data_byte;
    end
  end

  // ---------------- stage 2: decode and run emit ----------------
  phase_t           phase_r, phase_nxt;
  logic [RUN_W-1:0] pend_r, pend_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic             emit, rle_run, beyond, done_c, out_load;
  logic [RUN_W-1:0] cnt, run_len;
  logic [TOTAL_W-1:0] rem;
  colour_ctrl_t     cctrl;
  rgba_t            mapped, run_col;

  prid_colour_map u_colour (
    .entry  (pal_rd_r),
    .ctrl   (cctrl),
    .colour (mapped)
  );

  assign run_col = rle_run ? '0 : mapped;
  assign beyond  = {1'b0, pos_r} >= total_r;
  assign rem     = total_r - {1'b0, pos_r};
  assign done_c  = TOTAL_W'(cnt) >= rem;
  assign run_len = done_c ? rem[RUN_W-1:0] : cnt;

  always_comb begin
    emit              = 1'b0;
    rle_run           = 1'b0;
    cnt               = RUN_W'(1);
    cctrl.own_palette = flags_r[FLG_OWN_PAL];
    cctrl.transparent = flags_r[FLG_TRANSP];
    cctrl.plain       = 1'b1;
    phase_nxt         = phase_r;
    pend_nxt          = pend_r;
    pos_nxt           = pos_r;
    out_load          = 1'b0;
    if (s1_go) begin
      if (s1_action_r == ACT_START) begin
        pos_nxt   = '0;
        phase_nxt = PH_HEADER;
        pend_nxt  = '0;
      end else if (s1_action_r == ACT_DATA) begin
        unique case (phase_r)
          PH_HEADER: begin
            if (flags_r[FLG_RLE]) begin
              if (s1_byte_r > RLE_RUN_BASE) begin
                emit    = 1'b1;
                rle_run = 1'b1;
                cnt     = s1_byte_r[RUN_W-1:0];   // byte - 128
              end else if (s1_byte_r != 8'd0) begin
                pend_nxt  = RUN_W'(s1_byte_r - 8'd1);
                phase_nxt = PH_LITERAL;
              end
            end else if (s1_byte_r > REPEAT_BASE) begin
              pend_nxt  = RUN_W'(s1_byte_r - REPEAT_BASE);
              phase_nxt = PH_REPEAT;
            end else begin
              emit = 1'b1;
            end
          end
          PH_LITERAL: begin
            if (pend_r == '0) phase_nxt = PH_HEADER;
            else              pend_nxt  = pend_r - RUN_W'(1);
            emit        = 1'b1;
            cctrl.plain = 1'b0;
          end
          PH_REPEAT: begin
            phase_nxt = PH_HEADER;
            emit      = 1'b1;
            cnt       = pend_r;
          end
          PH_IDLE: ;
        endcase
        if (emit) begin
          if (beyond) begin
            phase_nxt = PH_IDLE;
          end else begin
            out_load = 1'b1;
            if (done_c) begin
              phase_nxt = PH_IDLE;
              pos_nxt   = '0;
            end else begin
              pos_nxt = pos_r + POS_W'(run_len);
            end
          end
        end
      end
    end
  end

  // ---------------- result register ----------------
  logic [POS_W-1:0] off_r;
  logic [RUN_W-1:0] len_r;
  rgba_t            col_r;
  logic             done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pend_r  <= '0;
      pos_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      pos_r   <= pos_nxt;
      out_v_r <= s1_go ? out_load : (out_v_r && !out_chan.ready);
    end
    if (out_load) begin
      off_r  <= pos_r;
      len_r  <= run_len;
      col_r  <= run_col;
      done_r <= done_c;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.pixel_offset = off_r;
  assign out_chan.run_length   = len_r;
  assign out_chan.pixel_red    = col_r.red;
  assign out_chan.pixel_green  = col_r.green;
  assign out_chan.pixel_blue   = col_r.blue;
  assign out_chan.pixel_alpha  = col_r.alpha;
  assign out_chan.image_done   = done_r;

  // ---------------- assertions ----------------
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> len_r != '0)
    else $error("empty run in output register");

  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && done_r |-> (TOTAL_W'(off_r) + TOTAL_W'(len_r)) == total_r)
    else $error("image_done run does not end at the last pixel");

  a_done_resets: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && done_c |=> pos_r == '0 && phase_r == PH_IDLE)
    else $error("decoder not idle after final run");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_v_r && out_v_r && !out_chan.ready)
    else $error("input stalled without a full pipe");

endmodule
